@@ hdl/disjoint_set_union_find_top_assert.svh @@
// assertion macros for the disjoint set block
// expects clk and arst_n in the scope of the module that uses them
`ifndef DISJOINT_SET_UNION_FIND_TOP_ASSERT_SVH
`define DISJOINT_SET_UNION_FIND_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define DSU_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define DSU_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

@@ hdl/dsu_pkg.sv @@
// shared constants for the disjoint set block
// no dependencies
`default_nettype none

package dsu_pkg;
	localparam int NUM_ELEMENTS_DEF = 1024;
	localparam int ELEM_W           = 10;
endpackage

`default_nettype wire

@@ hdl/dsu_ram.sv @@
// generic single write, single read ram with registered read data
// write-first on a same-address collision; no dependencies
`default_nettype none

module dsu_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

@@ hdl/disjoint_set_union_find_top.sv @@
// Union-find table with union by size and full path compression. After reset the
// block sweeps the table, one entry a cycle, through all NUM_ELEMENTS entries before
// taking its first word. A request runs a find from elem_a, then one from elem_b (after
// the first find has compressed its path), then a join step, and a link step when a
// union merges two sets; no new request is taken until it is through. Each find walks
// the parent chain through the single read port of the table, one link a cycle, then
// walks it again rewriting each node onto the root. A result word left waiting at the
// output holds the block in its done state and stalls the input. Out-of-range requests
// go straight to the done state and answer 0.
// depends on dsu_pkg, dsu_ram and disjoint_set_union_find_top_assert.svh
`default_nettype none

module disjoint_set_union_find_top #(
	parameter int NUM_ELEMENTS = dsu_pkg::NUM_ELEMENTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       mode,
	input  wire logic [dsu_pkg::ELEM_W-1:0] elem_a,
	input  wire logic [dsu_pkg::ELEM_W-1:0] elem_b,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            answer
);
	`include "disjoint_set_union_find_top_assert.svh"

	localparam int AW = $clog2(NUM_ELEMENTS);
	localparam int EW = AW + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ELEMENTS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_COMP  = 3'd3;
	localparam logic [2:0] S_JOIN  = 3'd4;
	localparam logic [2:0] S_LINK  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [AW-1:0] cur_q, start_q, root_q, ra_q, child_q, parent_q;
	logic [EW-1:0] ta_q, tb_q;
	logic [dsu_pkg::ELEM_W-1:0] elem_b_q;
	logic          side_q, mode_q, ans_q, out_valid_q, answer_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0] addr_a, addr_b, link_idx;
	logic          is_root, cur_is_root, comp_done, in_fire, range_ok, ta_bigger;
	logic [EW-1:0] size_sum;

	dsu_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_ELEMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign range_ok    = (32'(elem_a) < 32'(NUM_ELEMENTS)) && (32'(elem_b) < 32'(NUM_ELEMENTS));
	assign addr_a      = AW'(elem_a);
	assign addr_b      = AW'(elem_b_q);
	assign link_idx    = ram_rdata[AW-1:0];
	assign is_root     = ram_rdata[EW-1];
	assign cur_is_root = (cur_q == root_q);
	assign comp_done   = cur_is_root || (link_idx == root_q);
	assign size_sum    = ta_q + tb_q;
	assign ta_bigger   = ($signed(ta_q) < $signed(tb_q));
	assign out_valid   = out_valid_q;
	assign answer      = answer_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = {1'b0, root_q};
		ram_raddr = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '1;
			end
			S_IDLE: begin
				ram_raddr = addr_a;
			end
			S_WALK: begin
				ram_raddr = is_root ? start_q : link_idx;
			end
			S_COMP: begin
				ram_we    = !cur_is_root;
				ram_raddr = comp_done ? addr_b : link_idx;
			end
			S_JOIN: begin
				ram_we    = !mode_q && (ra_q != root_q);
				ram_waddr = ta_bigger ? ra_q : root_q;
				ram_wdata = size_sum;
			end
			S_LINK: begin
				ram_we    = 1'b1;
				ram_waddr = child_q;
				ram_wdata = {1'b0, parent_q};
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			cur_q       <= '0;
			start_q     <= '0;
			root_q      <= '0;
			ra_q        <= '0;
			child_q     <= '0;
			parent_q    <= '0;
			ta_q        <= '0;
			tb_q        <= '0;
			elem_b_q    <= '0;
			side_q      <= 1'b0;
			mode_q      <= 1'b0;
			ans_q       <= 1'b0;
			out_valid_q <= 1'b0;
			answer_q    <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						mode_q   <= mode;
						elem_b_q <= elem_b;
						side_q   <= 1'b0;
						cur_q    <= addr_a;
						start_q  <= addr_a;
						if (range_ok) begin
							state_q <= S_WALK;
						end else begin
							ans_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_WALK: begin
					if (is_root) begin
						root_q <= cur_q;
						if (side_q) begin
							tb_q <= ram_rdata;
						end else begin
							ta_q <= ram_rdata;
						end
						cur_q   <= start_q;
						state_q <= S_COMP;
					end else begin
						cur_q <= link_idx;
					end
				end
				S_COMP: begin
					if (comp_done) begin
						if (!side_q) begin
							ra_q    <= root_q;
							side_q  <= 1'b1;
							cur_q   <= addr_b;
							start_q <= addr_b;
							state_q <= S_WALK;
						end else begin
							state_q <= S_JOIN;
						end
					end else begin
						cur_q <= link_idx;
					end
				end
				S_JOIN: begin
					if (mode_q) begin
						ans_q   <= (ra_q == root_q);
						state_q <= S_DONE;
					end else if (ra_q == root_q) begin
						ans_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						ans_q    <= 1'b1;
						child_q  <= ta_bigger ? root_q : ra_q;
						parent_q <= ta_bigger ? ra_q : root_q;
						state_q  <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						answer_q <= ans_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DSU_ASSERT_NEXT(a_bad_index_zero, in_fire && !range_ok, (state_q == S_DONE) && !ans_q, "out-of-range word must answer zero")
	`DSU_ASSERT_NOW(a_no_write_idle, (state_q == S_IDLE) || (state_q == S_DONE), !ram_we, "table written while no request in flight")
	`DSU_ASSERT_NOW(a_comp_to_root, ram_we && (state_q == S_COMP), ram_wdata == {1'b0, root_q}, "compression must point at the root")
	`DSU_ASSERT_NOW(a_roots_negative, state_q == S_JOIN, ta_q[EW-1] && tb_q[EW-1], "root entries must hold a negated size")
	`DSU_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result word raised outside the done state")
endmodule

`default_nettype wire
